// ----- hw/rtl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared widths, item codes and controller/datapath interface types for the
// sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned CFG_W      = 7;   // entry_count register
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned POS_W      = 6;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // write the input value into its slot
    logic start;     // begin a search: set bounds, latch key, issue first read
    logic step;      // compare the probed entry and narrow the interval
    logic load_out;  // move the result into the output register
  } stbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;   // another probe follows
  } stbs_sts_t;

endpackage

// ----- hw/rtl/stbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for load and search items; owns the handshakes and the output
// valid flag.
// ----------------------------------------------------------------------------
module stbs_ctrl import stbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      mode_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  stbs_sts_t sts_i,
  output stbs_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_xfer;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (mode_i == MODE_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = sts_i.more ? ST_SEARCH : ST_FINISH;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (!sts_i.more) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a pending result must never be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_o.load_out)
    else $error("stbs_ctrl: output register overwritten while stalled");

  // searching is only entered from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SEARCH) |-> $past(state_q) == ST_IDLE)
    else $error("stbs_ctrl: search entered from wrong state");

  // a search always finishes through the result stage before idling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH && !sts_i.more |=> state_q == ST_FINISH)
    else $error("stbs_ctrl: search ended without result stage");

endmodule

// ----- hw/rtl/stbs_datapath.sv -----
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, entry count register, search interval and key registers,
// probe compare and output payload register.
// ----------------------------------------------------------------------------
module stbs_datapath import stbs_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  logic [SLOT_W-1:0]            slot_i,
  input  logic signed [IN_VALUE_W-1:0] value_i,
  input  stbs_cmd_t                    cmd_i,
  output stbs_sts_t                    sts_o,
  output logic                         found_o,
  output logic [POS_W-1:0]             position_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [VALUE_BITS-1:0] mem [TABLE_ENTRIES];

  logic [CFG_W-1:0]      entry_count_q;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [VALUE_BITS-1:0] rd_data_q;
  logic [CNT_W-1:0]      low_q, hi_q, low_n, hi_n;  // interval is [low, hi)
  logic [IDX_W-1:0]      mid_q, mid_n;
  logic                  found_q;
  logic [POS_W-1:0]      pos_q;
  logic                  out_found_q;
  logic [POS_W-1:0]      out_position_q;

  logic [31:0]           cnt_wide;
  logic [CNT_W-1:0]      count;
  logic [SUM_W-1:0]      mid_sum;
  logic                  gt, lt, eq;
  logic                  advance;
  logic                  wr_en;

  // counts above the table size saturate
  assign cnt_wide = (32'(entry_count_q) > TABLE_ENTRIES) ? 32'(TABLE_ENTRIES)
                                                        : 32'(entry_count_q);
  assign count    = cnt_wide[CNT_W-1:0];

  assign key_d = VALUE_BITS'($signed(value_i));

  assign gt = $signed(key_q) > $signed(rd_data_q);
  assign lt = $signed(key_q) < $signed(rd_data_q);
  assign eq = !gt && !lt;

  always_comb begin
    low_n = low_q;
    hi_n  = hi_q;
    if (cmd_i.start) begin
      low_n = '0;
      hi_n  = count;
    end else if (gt) begin
      low_n = CNT_W'(mid_q) + CNT_W'(1);
    end else if (lt) begin
      hi_n = CNT_W'(mid_q);
    end
  end

  // floor((low + high) / 2) with high = hi - 1
  assign mid_sum = SUM_W'(low_n) + SUM_W'(hi_n) - SUM_W'(1);
  assign mid_n   = IDX_W'(mid_sum[SUM_W-1:1]);

  assign sts_o.more  = (low_n < hi_n) && (cmd_i.start || !eq);

  assign advance = (cmd_i.start || cmd_i.step) && sts_o.more;
  assign wr_en   = cmd_i.load && (32'(slot_i) < TABLE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[IDX_W'(slot_i)] <= key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_data_q <= mem[mid_n];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      low_q <= low_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
    if (cmd_i.start) begin
      key_q   <= key_d;
      found_q <= 1'b0;
      pos_q   <= '0;
    end else if (cmd_i.step) begin
      found_q <= eq;
      pos_q   <= eq ? POS_W'(mid_q) : '0;
    end
    if (cmd_i.load_out) begin
      out_found_q    <= found_q;
      out_position_q <= pos_q;
    end
  end

  assign found_o    = out_found_q;
  assign position_o = out_position_q;

  // each probe works on a nonempty interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> low_q < hi_q)
    else $error("stbs_datapath: probe on empty interval");

  // the probed slot lies inside the interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (CNT_W'(mid_q) >= low_q) && (CNT_W'(mid_q) < hi_q))
    else $error("stbs_datapath: midpoint outside interval");

  // a mismatching search reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !eq |=> !found_q && pos_q == '0)
    else $error("stbs_datapath: not-found result with nonzero position");

endmodule

// ----- hw/rtl/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted signed table with per-slot loads and binary search lookups.
// ----------------------------------------------------------------------------
// Load: no result; the next item is taken the cycle after.
// Search: P probes, P <= floor(log2(count)) + 1 (7 for 64 entries); the result
//   moves to the output register once it is free; no item is taken before then.
// Each probe is one registered table read plus a compare that also forms the next midpoint.
// Reset clears the controller, output valid and entry_count; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [SLOT_W-1:0]            slot_i,
  input  logic signed [IN_VALUE_W-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [POS_W-1:0]             position_o
);

  stbs_cmd_t cmd;
  stbs_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stbs_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VALUE_BITS    (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .slot_i      (slot_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .found_o     (found_o),
    .position_o  (position_o)
  );

endmodule
